[rtl/core/scf_pkg.sv]
package scf_pkg;

	localparam logic [7:0] CRC_POLY   = 8'hD5;
	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [7:0] START_BYTE = 8'h53;
	localparam logic [7:0] LEN_BYTE   = 8'h0B;
	localparam logic [7:0] WRITE_CMD  = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h45;

	localparam logic [15:0] OBJECT_INDEX_RESET    = 16'h60FF;
	localparam logic [7:0]  OBJECT_SUBINDEX_RESET = 8'h00;

	localparam logic REG_OBJECT_INDEX    = 1'b0;
	localparam logic REG_OBJECT_SUBINDEX = 1'b1;

	// frame byte positions, transmit order
	localparam logic [3:0] POS_START   = 4'd0;
	localparam logic [3:0] POS_LEN     = 4'd1;
	localparam logic [3:0] POS_NODE    = 4'd2;
	localparam logic [3:0] POS_CMD     = 4'd3;
	localparam logic [3:0] POS_IDX_LO  = 4'd4;
	localparam logic [3:0] POS_IDX_HI  = 4'd5;
	localparam logic [3:0] POS_SUB     = 4'd6;
	localparam logic [3:0] POS_SPEED_0 = 4'd7;
	localparam logic [3:0] POS_SPEED_1 = 4'd8;
	localparam logic [3:0] POS_SPEED_2 = 4'd9;
	localparam logic [3:0] POS_SPEED_3 = 4'd10;
	localparam logic [3:0] POS_CRC     = 4'd11;
	localparam logic [3:0] POS_END     = 4'd12;

	typedef struct packed {
		logic [7:0]         node_address;
		logic signed [31:0] target_speed;
	} cmd_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} result_t;

	// variable part of one frame plus the running CRC
	typedef struct packed {
		logic [7:0]  node;
		logic [15:0] index;
		logic [7:0]  subindex;
		logic [31:0] speed;
		logic [7:0]  crc;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/scf_crc_pipe.sv]
module scf_crc_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  scf_pkg::cmd_t   cmd,
	input  logic [15:0]     object_index,
	input  logic [7:0]      object_subindex,
	output logic            in_busy,
	output logic            out_valid,
	output scf_pkg::frame_t out_frame,
	input  logic            out_take
);
	import scf_pkg::*;

	logic   v_s1, v_s2, v_s3;
	frame_t frm_s1, frm_s2, frm_s3;
	logic   adv1, adv2, adv3;
	logic   take_in;
	logic [7:0] crc_a, crc_b, crc_c;

	assign adv3    = out_take;
	assign adv2    = v_s2 && (!v_s3 || adv3);
	assign adv1    = v_s1 && (!v_s2 || adv2);
	assign in_busy = v_s1 && !adv1;
	assign take_in = in_valid && !in_busy;

	// bytes 1..4: length, node, command, index low
	always_comb begin
		crc_a = crc8_byte(CRC_INIT, LEN_BYTE);
		crc_a = crc8_byte(crc_a, cmd.node_address);
		crc_a = crc8_byte(crc_a, WRITE_CMD);
		crc_a = crc8_byte(crc_a, object_index[7:0]);
	end

	// bytes 5..7: index high, subindex, speed byte 0
	always_comb begin
		crc_b = crc8_byte(frm_s1.crc, frm_s1.index[15:8]);
		crc_b = crc8_byte(crc_b, frm_s1.subindex);
		crc_b = crc8_byte(crc_b, frm_s1.speed[7:0]);
	end

	// bytes 8..10: upper speed bytes
	always_comb begin
		crc_c = crc8_byte(frm_s2.crc, frm_s2.speed[15:8]);
		crc_c = crc8_byte(crc_c, frm_s2.speed[23:16]);
		crc_c = crc8_byte(crc_c, frm_s2.speed[31:24]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take_in) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			frm_s1.node     <= cmd.node_address;
			frm_s1.index    <= object_index;
			frm_s1.subindex <= object_subindex;
			frm_s1.speed    <= cmd.target_speed;
			frm_s1.crc      <= crc_a;
		end
		if (adv1) begin
			frm_s2.node     <= frm_s1.node;
			frm_s2.index    <= frm_s1.index;
			frm_s2.subindex <= frm_s1.subindex;
			frm_s2.speed    <= frm_s1.speed;
			frm_s2.crc      <= crc_b;
		end
		if (adv2) begin
			frm_s3.node     <= frm_s2.node;
			frm_s3.index    <= frm_s2.index;
			frm_s3.subindex <= frm_s2.subindex;
			frm_s3.speed    <= frm_s2.speed;
			frm_s3.crc      <= crc_c;
		end
	end

	assign out_valid = v_s3;
	assign out_frame = frm_s3;

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> v_s3)
		else $error("frame taken from empty stage");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> v_s1)
		else $error("accepted word not in first stage");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_take |=> v_s3 && $stable(frm_s3))
		else $error("stalled frame lost or changed");
endmodule

[rtl/core/speed_command_framer_crc8.sv]
// channel   dir  handshake               payload
// command   in   start && !busy          cmd (node_address, target_speed)
// frame     out  strobe, one cycle/word  result (frame_byte, last_byte)
// config    in   write_en                reg_index, write_data
//
// One command gives 13 bytes, one per cycle; the byte serializer sets the
// sustained command rate. CRC runs in three register stages, so when idle
// an accepted command passes them and the frame register before its first
// byte is strobed.
// Up to three commands wait in the CRC stages while a frame is sent; busy
// rises only when all of them are full. Reset clears all valid bits and
// loads the register defaults.
module speed_command_framer_crc8 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  scf_pkg::cmd_t    cmd,
	output logic             strobe,
	output scf_pkg::result_t result,
	input  logic             write_en,
	input  logic             reg_index,
	input  logic [15:0]      write_data
);
	import scf_pkg::*;

	logic [15:0] obj_index_q;
	logic [7:0]  obj_subindex_q;
	logic        pipe_valid;
	frame_t      pipe_frame;
	frame_t      frame_q;
	logic [3:0]  cnt_q;
	logic        active_q;
	logic        load;
	logic [7:0]  byte_mux;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_index_q    <= OBJECT_INDEX_RESET;
			obj_subindex_q <= OBJECT_SUBINDEX_RESET;
		end else if (write_en) begin
			case (reg_index)
				REG_OBJECT_INDEX:    obj_index_q    <= write_data;
				REG_OBJECT_SUBINDEX: obj_subindex_q <= write_data[7:0];
				default: ;
			endcase
		end
	end

	scf_crc_pipe u_crc (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start),
		.cmd            (cmd),
		.object_index   (obj_index_q),
		.object_subindex(obj_subindex_q),
		.in_busy        (busy),
		.out_valid      (pipe_valid),
		.out_frame      (pipe_frame),
		.out_take       (load)
	);

	// take the next frame when idle or as the closing byte of the current one goes out
	assign load = pipe_valid && (!active_q || cnt_q == POS_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= POS_START;
		end else if (load) begin
			active_q <= 1'b1;
			cnt_q    <= POS_START;
		end else if (active_q) begin
			if (cnt_q == POS_END) begin
				active_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= pipe_frame;
		end
	end

	always_comb begin
		case (cnt_q)
			POS_START:   byte_mux = START_BYTE;
			POS_LEN:     byte_mux = LEN_BYTE;
			POS_NODE:    byte_mux = frame_q.node;
			POS_CMD:     byte_mux = WRITE_CMD;
			POS_IDX_LO:  byte_mux = frame_q.index[7:0];
			POS_IDX_HI:  byte_mux = frame_q.index[15:8];
			POS_SUB:     byte_mux = frame_q.subindex;
			POS_SPEED_0: byte_mux = frame_q.speed[7:0];
			POS_SPEED_1: byte_mux = frame_q.speed[15:8];
			POS_SPEED_2: byte_mux = frame_q.speed[23:16];
			POS_SPEED_3: byte_mux = frame_q.speed[31:24];
			POS_CRC:     byte_mux = frame_q.crc;
			POS_END:     byte_mux = END_BYTE;
			default:     byte_mux = END_BYTE;
		endcase
	end

	assign strobe            = active_q;
	assign result.frame_byte = byte_mux;
	assign result.last_byte  = active_q && (cnt_q == POS_END);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cnt_q <= POS_END)
		else $error("byte counter past end of frame");
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_byte |=> strobe)
		else $error("frame interrupted before closing byte");
	a_frame_opens: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> result.frame_byte == START_BYTE)
		else $error("frame does not open with start byte");
	a_load_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		load && active_q |-> result.last_byte)
		else $error("new frame loaded mid-frame");
endmodule

[test/tb_speed_command_framer_crc8.sv]
module tb_speed_command_framer_crc8;
	timeunit 1ns;
	timeprecision 1ps;

	import scf_pkg::*;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic        busy;
	cmd_t        cmd        = '0;
	logic        strobe;
	result_t     result;
	logic        write_en   = 1'b0;
	logic        reg_index  = 1'b0;
	logic [15:0] write_data = '0;

	speed_command_framer_crc8 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.strobe     (strobe),
		.result     (result),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	// testbench copy of the configuration registers
	logic [15:0] cur_index    = OBJECT_INDEX_RESET;
	logic [7:0]  cur_subindex = OBJECT_SUBINDEX_RESET;

	cmd_t    pending_cmds[$];
	result_t expected_bytes[$];
	int      errors     = 0;
	int      gap_left   = 0;
	int      burst_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("** speed_command_framer_crc8: FAILED **");
		$finish;
	end

	// right-shifting CRC-8, one data bit at a time
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ data[i];
			r  = {1'b0, r[7:1]};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic void predict_frame(input cmd_t c);
		logic [7:0] fb [13];
		logic [7:0] crc;
		result_t    w;
		fb[POS_START]   = START_BYTE;
		fb[POS_LEN]     = LEN_BYTE;
		fb[POS_NODE]    = c.node_address;
		fb[POS_CMD]     = WRITE_CMD;
		fb[POS_IDX_LO]  = cur_index[7:0];
		fb[POS_IDX_HI]  = cur_index[15:8];
		fb[POS_SUB]     = cur_subindex;
		fb[POS_SPEED_0] = c.target_speed[7:0];
		fb[POS_SPEED_1] = c.target_speed[15:8];
		fb[POS_SPEED_2] = c.target_speed[23:16];
		fb[POS_SPEED_3] = c.target_speed[31:24];
		crc = CRC_INIT;
		for (int k = POS_LEN; k <= POS_SPEED_3; k++) begin
			crc = crc8_step(crc, fb[k]);
		end
		fb[POS_CRC] = crc;
		fb[POS_END] = END_BYTE;
		for (int k = 0; k < 13; k++) begin
			w.frame_byte = fb[k];
			w.last_byte  = (k == POS_END);
			expected_bytes.push_back(w);
		end
	endfunction

	function automatic void note_mismatch(input string what, input result_t want,
			input result_t got);
		errors++;
		if (errors <= 10) begin
			$display("%s: expected byte %02h last %0b, got byte %02h last %0b",
				what, want.frame_byte, want.last_byte, got.frame_byte, got.last_byte);
		end
	endfunction

	// driver: bursts of commands with random gaps between them
	always @(posedge clk) begin
		if (!arst_n) begin
			start      <= 1'b0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (start && !busy) begin
				predict_frame(pending_cmds.pop_front());
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					start <= 1'b1;
					cmd   <= pending_cmds[0];
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed word against the oldest expected one
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_bytes.size() == 0) begin
				note_mismatch("unexpected word", '0, result);
			end else begin
				if (result.frame_byte !== expected_bytes[0].frame_byte ||
						result.last_byte !== expected_bytes[0].last_byte) begin
					note_mismatch("word mismatch", expected_bytes[0], result);
				end
				void'(expected_bytes.pop_front());
			end
		end
	end

	function automatic logic signed [31:0] rand_speed();
		case ($urandom_range(0, 11))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic add_cmd(input logic [7:0] node, input logic signed [31:0] speed);
		cmd_t c;
		c.node_address = node;
		c.target_speed = speed;
		pending_cmds.push_back(c);
	endtask

	// hold until every queued command is sent and its frame has come back
	task automatic drain();
		do begin
			@(negedge clk);
		end while (pending_cmds.size() != 0 || expected_bytes.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		@(posedge clk);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= data;
		if (idx == REG_OBJECT_INDEX) begin
			cur_index = data;
		end else begin
			cur_subindex = data[7:0];
		end
		@(posedge clk);
		write_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_directed();
		add_cmd(8'h00, 32'sh0000_0000);
		add_cmd(8'hFF, -32'sd1);
		add_cmd(8'h01, 32'sh7FFF_FFFF);
		add_cmd(8'h80, 32'sh8000_0000);
		add_cmd(8'h55, 32'sh55AA_55AA);
		add_cmd(8'hAA, 32'shAA55_AA55);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults after reset
		add_directed();
		add_cmd(8'h7F, 32'sd1);
		add_cmd(8'h0F, -32'sd2);
		drain();

		write_reg(REG_OBJECT_INDEX, 16'h0000);
		write_reg(REG_OBJECT_SUBINDEX, 16'h0000);
		add_directed();
		drain();

		// upper bits of the subindex write are dropped
		write_reg(REG_OBJECT_INDEX, 16'hFFFF);
		write_reg(REG_OBJECT_SUBINDEX, 16'hFFFF);
		add_directed();
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(REG_OBJECT_INDEX, 16'($urandom));
			write_reg(REG_OBJECT_SUBINDEX, 16'($urandom));
			for (int n = 0; n < 24; n++) begin
				add_cmd(8'($urandom), rand_speed());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			errors++;
			$display("%0d expected words never arrived", expected_bytes.size());
		end
		if (errors == 0) begin
			$display("** speed_command_framer_crc8: PASSED **");
		end else begin
			$display("** speed_command_framer_crc8: FAILED **");
		end
		$finish;
	end

endmodule
